// File: rtl/core/bdm_pkg.sv
// bdm_pkg: shared widths and the emission control struct for the
// binary descriptor majority unit. No dependencies.
package bdm_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned NLanes = ByteW;

  typedef struct packed {
    logic load;
    logic last;
    logic ovf;
  } bdm_emit_t;

endpackage

// File: rtl/core/bdm_lane.sv
// bdm_lane: one bit-position counter lane, a count memory with registered read,
// read-modify-write update with write-to-read bypass; entries at or past the
// set's fill count read as zero. Depends on bdm_pkg.
module bdm_lane #(
  parameter int unsigned MaxDescBytes = 64,
  parameter int unsigned CntW         = 10,
  parameter int unsigned AddrW        = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             rd_hit_i,
  input  logic             inc_en_i,
  input  logic             inc_bit_i,
  input  logic [CntW:0]    thr_i,
  output logic             vote_o
);
  import bdm_pkg::*;

  logic [CntW-1:0]         mem_q [MaxDescBytes];
  logic [CntW-1:0]         mem_rd_q;
  logic                    rd_vld_q;
  logic                    fwd_q;
  logic [CntW-1:0]         fwd_data_q;
  logic                    s1_vld_q;
  logic [AddrW-1:0]        s1_addr_q;
  logic                    s1_bit_q;
  logic [CntW-1:0]         cur;
  logic [CntW-1:0]         wr_data;

  assign cur     = fwd_q ? fwd_data_q : (rd_vld_q ? mem_rd_q : '0);
  assign wr_data = cur + CntW'(s1_bit_q);
  assign vote_o  = {1'b0, cur} >= thr_i;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mem_rd_q <= mem_q[rd_addr_i];
    end
    if (s1_vld_q) begin
      mem_q[s1_addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data;
      s1_addr_q  <= rd_addr_i;
      s1_bit_q   <= inc_bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      fwd_q     <= 1'b0;
      s1_vld_q  <= 1'b0;
    end else begin
      s1_vld_q <= rd_en_i & inc_en_i;
      if (rd_en_i) begin
        rd_vld_q <= rd_hit_i;
        fwd_q    <= s1_vld_q && (s1_addr_q == rd_addr_i);
      end
    end
  end

endmodule

// File: rtl/core/bdm_out.sv
// bdm_out: merges the lane votes into one result byte and holds it in the
// output register until the downstream transfer. Depends on bdm_pkg.
module bdm_out (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdm_pkg::bdm_emit_t        emit_i,
  input  logic [bdm_pkg::NLanes-1:0] votes_i,
  output logic                      free_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [bdm_pkg::ByteW-1:0] m_axis_tdata,  // [7:0] avg_byte
  output logic                      m_axis_tlast,  // last_byte
  output logic [0:0]                m_axis_tuser   // [0] overflow
);
  import bdm_pkg::*;

  logic             vld_q;
  logic [ByteW-1:0] data_q;
  logic             last_q;
  logic             ovf_q;

  assign free_o        = !vld_q || m_axis_tready;
  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = ovf_q;

  always_ff @(posedge clk_i) begin
    if (emit_i.load && free_o) begin
      data_q <= votes_i;
      last_q <= emit_i.last;
      ovf_q  <= emit_i.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= emit_i.load;
    end
  end

endmodule

// File: rtl/core/binary_descriptor_majority_unit.sv
// binary_descriptor_majority_unit: top level; eight counter lanes, set/row
// control, emission sequencer and the merging output stage.
// Depends on bdm_pkg, bdm_lane, bdm_out.
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] desc_byte, tlast last_descriptor
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata[7:0] avg_byte, tlast last_byte,
//           |     |                              | tuser[0] overflow
//  cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_data_i[6:0] desc_bytes
//
// Streaming: one descriptor byte per cycle; each lane does a read-modify-write
// on its count memory over two stages with a bypass for back-to-back hits.
// At set end the input stalls while the averaged descriptor is read out,
// one result byte at a time (count memory read, then vote); m_axis stalls add to it.
// Reset and the end of each emission zero a fill count; count entries at or
// past it read as zero, so no clearing pass is needed.
module binary_descriptor_majority_unit #(
  parameter int unsigned MAX_DESC_BYTES = 64,
  parameter int unsigned MAX_ROWS       = 1023
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [bdm_pkg::ByteW-1:0] s_axis_tdata,  // [7:0] desc_byte
  input  logic                      s_axis_tlast,  // last_descriptor
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [bdm_pkg::ByteW-1:0] m_axis_tdata,  // [7:0] avg_byte
  output logic                      m_axis_tlast,  // last_byte
  output logic [0:0]                m_axis_tuser,  // [0] overflow
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bdm_pkg::CfgW-1:0]  cfg_data_i     // [6:0] desc_bytes
);
  import bdm_pkg::*;

  localparam int unsigned AddrW = (MAX_DESC_BYTES > 1) ? $clog2(MAX_DESC_BYTES) : 1;
  localparam int unsigned LenW  = $clog2(MAX_DESC_BYTES + 1);
  localparam int unsigned CntW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CmpW  = (LenW > CfgW) ? LenW + 1 : CfgW + 1;

  typedef enum logic [1:0] {
    StRun,
    StEmitRd,
    StEmitWr
  } state_e;

  state_e           state_q;
  logic [CfgW-1:0]  cfg_q;
  logic [AddrW-1:0] pos_q;
  logic [AddrW-1:0] emit_cnt_q;
  logic [CntW-1:0]  row_q;
  logic             ovf_q;
  logic [LenW-1:0]  fill_q;

  logic [LenW-1:0]  len_eff;
  logic             in_xfer;
  logic             counting;
  logic             row_end;
  logic             emit_last;
  logic             out_free;
  logic             lane_rd_en;
  logic [AddrW-1:0] lane_rd_addr;
  logic             lane_rd_hit;
  logic             clr;
  logic [CntW:0]    thr;
  logic [NLanes-1:0] votes;
  bdm_emit_t        emit;

  always_comb begin
    if (cfg_q == '0) begin
      len_eff = LenW'(1);
    end else if (CmpW'(cfg_q) > CmpW'(MAX_DESC_BYTES)) begin
      len_eff = LenW'(MAX_DESC_BYTES);
    end else begin
      len_eff = LenW'(cfg_q);
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StRun);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign counting      = (row_q != CntW'(MAX_ROWS));
  assign row_end       = (LenW'(pos_q) + LenW'(1)) >= len_eff;
  assign emit_last     = (LenW'(emit_cnt_q) + LenW'(1)) == len_eff;
  assign thr           = ({1'b0, row_q} + (CntW + 1)'(1)) >> 1;

  assign lane_rd_en   = (in_xfer && counting) || (state_q == StEmitRd);
  assign lane_rd_addr = (state_q == StRun) ? pos_q : emit_cnt_q;
  assign lane_rd_hit  = LenW'(lane_rd_addr) < fill_q;
  assign clr          = (state_q == StEmitWr) && out_free && emit_last;

  assign emit.load = (state_q == StEmitWr);
  assign emit.last = emit_last;
  assign emit.ovf  = ovf_q;

  for (genvar gi = 0; gi < NLanes; gi++) begin : g_lane
    bdm_lane #(
      .MaxDescBytes(MAX_DESC_BYTES),
      .CntW        (CntW),
      .AddrW       (AddrW)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .rd_en_i  (lane_rd_en),
      .rd_addr_i(lane_rd_addr),
      .rd_hit_i (lane_rd_hit),
      .inc_en_i (state_q == StRun),
      .inc_bit_i(s_axis_tdata[gi]),
      .thr_i    (thr),
      .vote_o   (votes[gi])
    );
  end

  bdm_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (emit),
    .votes_i      (votes),
    .free_o       (out_free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StRun;
      cfg_q      <= CfgW'(64);
      pos_q      <= '0;
      emit_cnt_q <= '0;
      row_q      <= '0;
      ovf_q      <= 1'b0;
      fill_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      unique case (state_q)
        StRun: begin
          if (in_xfer) begin
            if (!counting) begin
              ovf_q <= 1'b1;
            end else if (LenW'(pos_q) >= fill_q) begin
              fill_q <= LenW'(pos_q) + LenW'(1);
            end
            if (row_end) begin
              pos_q <= '0;
              if (counting) begin
                row_q <= row_q + CntW'(1);
              end
              if (s_axis_tlast) begin
                emit_cnt_q <= '0;
                state_q    <= StEmitRd;
              end
            end else begin
              pos_q <= pos_q + AddrW'(1);
            end
          end
        end
        StEmitRd: begin
          state_q <= StEmitWr;
        end
        StEmitWr: begin
          if (out_free) begin
            if (emit_last) begin
              row_q   <= '0;
              pos_q   <= '0;
              ovf_q   <= 1'b0;
              fill_q  <= '0;
              state_q <= StRun;
            end else begin
              emit_cnt_q <= emit_cnt_q + AddrW'(1);
              state_q    <= StEmitRd;
            end
          end
        end
        default: begin
          state_q <= StRun;
        end
      endcase
    end
  end

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= CntW'(MAX_ROWS))
    else $error("row count past limit");

  a_set_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && row_end && s_axis_tlast) |=> (state_q == StEmitRd && emit_cnt_q == '0))
    else $error("set end did not start emission");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> (row_q == '0 && pos_q == '0 && !ovf_q && m_axis_tvalid && m_axis_tlast))
    else $error("set state not cleared after last result");

  a_no_input_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StRun) |-> !lane_rd_en || (lane_rd_addr == emit_cnt_q))
    else $error("count memory update during emission");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for binary_descriptor_majority_unit; streams descriptor sets,
// predicts the per-bit majority vote of each set and checks every output transfer.
// Depends on bdm_pkg and the unit's RTL.
module tb;
  import bdm_pkg::*;

  localparam int unsigned MaxBytes     = 64;
  localparam int unsigned MaxRows      = 1023;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned MaxPrints    = 60;
  localparam int unsigned TotalItems   = 400;

  typedef enum int unsigned {FillRandom, FillOnes, FillZeros, FillSparse, FillDense} fill_e;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
    int unsigned      gap;
  } feed_item_t;

  typedef struct {
    logic [ByteW-1:0] avg;
    logic             last;
    logic             ovf;
  } vote_byte_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata;
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [ByteW-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic [0:0]       m_axis_tuser;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CfgW-1:0]  cfg_data_i;

  binary_descriptor_majority_unit #(
    .MAX_DESC_BYTES(MaxBytes),
    .MAX_ROWS      (MaxRows)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] desc_byte
    .s_axis_tlast (s_axis_tlast),   // last_descriptor
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [7:0] avg_byte
    .m_axis_tlast (m_axis_tlast),   // last_byte
    .m_axis_tuser (m_axis_tuser),   // [0] overflow
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)      // [6:0] desc_bytes
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  int unsigned     ones_cnt [MaxBytes*ByteW];
  int unsigned     rows_seen;
  int unsigned     byte_pos;
  bit              ovf_seen;
  logic [CfgW-1:0] cfg_len;

  feed_item_t  feed_q [$];
  vote_byte_t  vote_q [$];
  feed_item_t  cur;
  bit          have_cur;
  bit          tx_idle;
  bit          rx_idle;
  int unsigned rx_wait;
  int unsigned hold_cnt;
  int unsigned fed;
  int unsigned err_cnt;
  int unsigned idle_cycles;
  logic        in_xfer;
  logic        out_xfer;

  function automatic int unsigned eff_len();
    if (cfg_len == '0) return 1;
    if (cfg_len > MaxBytes) return MaxBytes;
    return cfg_len;
  endfunction

  function automatic void clear_votes();
    foreach (ones_cnt[i]) ones_cnt[i] = 0;
    rows_seen = 0;
    byte_pos  = 0;
    ovf_seen  = 1'b0;
  endfunction

  function automatic void absorb_byte(logic [ByteW-1:0] b, logic last_desc);
    int unsigned len;
    int unsigned pos;
    int unsigned thr;
    bit          counted;
    vote_byte_t  vb;
    len     = eff_len();
    pos     = (byte_pos >= MaxBytes) ? MaxBytes - 1 : byte_pos;
    counted = rows_seen < MaxRows;
    if (counted) begin
      for (int unsigned k = 0; k < ByteW; k++) ones_cnt[pos*ByteW + k] += b[ByteW-1-k];
    end else begin
      ovf_seen = 1'b1;
    end
    if (pos + 1 < len) begin
      byte_pos = pos + 1;
      return;
    end
    byte_pos = 0;
    if (counted) rows_seen++;
    if (!last_desc) return;
    thr = (rows_seen + 1) / 2;
    for (int unsigned n = 0; n < len; n++) begin
      vb.avg = '0;
      for (int unsigned k = 0; k < ByteW; k++) vb.avg[ByteW-1-k] = ones_cnt[n*ByteW + k] >= thr;
      vb.last = (n + 1 == len);
      vb.ovf  = ovf_seen;
      vote_q = {vote_q, vb};
    end
    clear_votes();
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_cnt < MaxPrints)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  // monitor, predictor update and watchdog
  always @(posedge clk_i) begin
    vote_byte_t want;
    in_xfer  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_xfer <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) cfg_len = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) absorb_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (vote_q.size() == 0) begin
          report_mismatch("result transfer with nothing pending", m_axis_tdata, 0);
        end else begin
          want = vote_q.pop_front();
          if (m_axis_tdata !== want.avg) report_mismatch("avg_byte", m_axis_tdata, want.avg);
          if (m_axis_tlast !== want.last) report_mismatch("last_byte", m_axis_tlast, want.last);
          if (m_axis_tuser[0] !== want.ovf)
            report_mismatch("overflow", m_axis_tuser[0], want.ovf);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("[%0t] no transfer for %0d cycles", $time, idle_cycles);
        $display("binary_descriptor_majority_unit verification failed");
        $finish;
      end
    end
  end

  // byte sender
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_xfer)) begin
      if (!have_cur && feed_q.size() != 0) begin
        cur      = feed_q.pop_front();
        have_cur = 1'b1;
      end
      if (have_cur && cur.gap != 0) begin
        cur.gap--;
        s_axis_tvalid <= 1'b0;
      end else if (have_cur) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cur.data;
        s_axis_tlast  <= cur.last;
        have_cur = 1'b0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_xfer) rx_wait = rx_idle ? $urandom_range(0, 10) : 0;
      if (hold_cnt != 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  function automatic logic [ByteW-1:0] fill_byte(fill_e f);
    case (f)
      FillOnes:   return 8'hFF;
      FillZeros:  return 8'h00;
      FillSparse: return 8'($urandom & $urandom);
      FillDense:  return 8'($urandom | $urandom);
      default:    return 8'($urandom);
    endcase
  endfunction

  task automatic queue_byte(input logic [ByteW-1:0] d, input logic l);
    feed_item_t it;
    it.data = d;
    it.last = l;
    it.gap  = tx_idle ? $urandom_range(0, 10) : 0;
    feed_q = {feed_q, it};
    fed++;
  endtask

  // head: byte count of the first row, to close a row left open earlier
  task automatic queue_set(input int unsigned nrows, input int unsigned len, input fill_e f,
                           input int unsigned head);
    int unsigned nb;
    for (int unsigned r = 0; r < nrows; r++) begin
      nb = (r == 0) ? head : len;
      for (int unsigned b = 0; b < nb; b++)
        queue_byte(fill_byte(f), (b == nb - 1) ? (r == nrows - 1) : ($urandom_range(0, 3) == 0));
    end
  endtask

  task automatic settle();
    while (feed_q.size() != 0 || have_cur || s_axis_tvalid || vote_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_len(input logic [CfgW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned v;
    int unsigned nsets;
    int unsigned nrows;
    int unsigned len;
    int unsigned head;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    have_cur      = 1'b0;
    rx_wait       = 0;
    hold_cnt      = 0;
    fed           = 0;
    err_cnt       = 0;
    idle_cycles   = 0;
    in_xfer       = 1'b0;
    out_xfer      = 1'b0;
    cfg_len       = 7'd64;
    clear_votes();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset length; receiver held off so emission backs up into the input
    tx_idle  = 1'b0;
    rx_idle  = 1'b1;
    hold_cnt = HoldCycles;
    queue_set(1, MaxBytes, FillDense, MaxBytes);
    queue_set(2, MaxBytes, FillRandom, MaxBytes);
    settle();

    // zero length acts as one byte
    tx_idle = 1'b1;
    set_len(7'd0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b1);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'hCC, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b1);
    settle();

    // last marks on inner bytes are ignored
    set_len(7'd3);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'h7E, 1'b0);
    queue_byte(8'h81, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    settle();

    // shrink mid-row: position past the new length closes the row,
    // then stale counts beyond the length must be gone
    set_len(7'd5);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    settle();
    set_len(7'd1);
    queue_byte(8'hFF, 1'b1);
    settle();
    set_len(7'd5);
    queue_set(1, 5, FillZeros, 5);
    settle();

    while (fed < TotalItems) begin
      case ($urandom_range(0, 9))
        0:       v = 0;
        1:       v = 127;
        2:       v = 64;
        3:       v = $urandom_range(9, 126);
        default: v = $urandom_range(1, 8);
      endcase
      set_len(v[CfgW-1:0]);
      len     = eff_len();
      tx_idle = $urandom_range(0, 2) != 0;
      rx_idle = $urandom_range(0, 2) != 0;
      nsets   = (len > 8) ? 1 : $urandom_range(1, 3);
      head    = (byte_pos + 1 >= len) ? 1 : len - byte_pos;
      repeat (nsets) begin
        nrows = (len > 8) ? $urandom_range(1, 2) : $urandom_range(1, 7);
        queue_set(nrows, len, fill_e'($urandom_range(0, 4)), head);
        head = len;
      end
      // occasionally leave a row open across the next length change
      if (len > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, len - 1)) queue_byte(8'($urandom), 1'($urandom));
      end
      settle();
    end

    settle();
    if (err_cnt == 0) begin
      $display("binary_descriptor_majority_unit verification clean");
    end else begin
      $display("binary_descriptor_majority_unit verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bdm_pkg.sv
rtl/core/bdm_lane.sv
rtl/core/bdm_out.sv
rtl/core/binary_descriptor_majority_unit.sv
sim/tb.sv
